FILE: sv/fce_pkg.sv
// ----------------------------------------------------------------------------
// fce_pkg
// Shared types and constants for the cluster chain table engine: command and
// status codes, the sequencer states and the input and result words.
// ----------------------------------------------------------------------------
package fce_pkg;

  // End-of-chain marker, also the fixed content of entry zero
  localparam logic [15:0] END_MARK = 16'hFFFF;

  // Default table depth and reset value of the usable entry count
  localparam int          DEF_TABLE_ENTRIES = 4096;
  localparam logic [11:0] DBC_RESET         = 12'd4095;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_SEEK  = 2'd2,
    CMD_LOAD  = 2'd3
  } fce_cmd_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NO_SPACE  = 2'd1,
    STAT_CHAIN_END = 2'd2,
    STAT_BAD_INDEX = 2'd3
  } fce_status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC_START,
    S_ALLOC_CNT,
    S_ALLOC_LINK,
    S_ALLOC_END,
    S_FREE_START,
    S_FREE_RUN,
    S_SEEK_START,
    S_SEEK_RUN,
    S_LOAD_START,
    S_LOAD_RUN,
    S_REPLY
  } fce_state_t;

  typedef struct packed {
    fce_cmd_t    command;
    logic [15:0] start_index;
    logic [11:0] amount;
    logic [15:0] entry_value;
  } fce_in_t;

  typedef struct packed {
    fce_status_t status;
    logic [15:0] result_index;
    logic [11:0] freed_count;
    logic [11:0] free_entries;
  } fce_out_t;

endpackage

FILE: sv/fat_chain_engine.sv
// ----------------------------------------------------------------------------
// fat_chain_engine
// File allocation table of 16-bit entries in one synchronous RAM. Allocates
// first-fit chains, frees and seeks along chains, and loads single entries.
// ----------------------------------------------------------------------------
// Sequence from accepting edge to result word: load reads, then writes the
//   entry; free and seek read one entry per link; allocate reads the table
//   in two scans (count, then link).
// Throughput: one command at a time; a new word is taken the cycle after the
//   result word is loaded, and loading waits while the output is stalled.
// Reset: a clearing pass over every entry with in_stall held high.
module fat_chain_engine
  import fce_pkg::*;
#(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  fce_in_t     in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output fce_out_t    out_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] cfg_data
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int OCC_W = $clog2(TABLE_ENTRIES + 1);

  // Flag an index that is reserved or beyond the table
  function automatic logic is_bad(logic [15:0] idx);
    is_bad = (idx == 16'd0) || (32'(idx) >= 32'(TABLE_ENTRIES));
  endfunction

  fce_state_t        state_r, state_nxt;
  fce_cmd_t          cmd_r, cmd_nxt;
  fce_status_t       status_r, status_nxt;
  logic [15:0]       cur_r, cur_nxt;
  logic [15:0]       value_r, value_nxt;
  logic [15:0]       result_r, result_nxt;
  logic [11:0]       amount_r, amount_nxt;
  logic [11:0]       remain_r, remain_nxt;
  logic [11:0]       cnt_r, cnt_nxt;
  logic [11:0]       freed_r, freed_nxt;
  logic [IDX_W-1:0]  prev_r, prev_nxt;
  logic [IDX_W-1:0]  scan_addr_r, scan_addr_nxt;
  logic              scan_on_r, scan_on_nxt;
  logic [IDX_W-1:0]  clr_addr_r, clr_addr_nxt;
  logic [OCC_W-1:0]  occ_r, occ_nxt;
  logic [11:0]       cfg_dbc_r;

  // RAM ports and read-side registers
  logic [15:0]       fat_mem [TABLE_ENTRIES];
  logic              mem_rd_en, mem_wr_en;
  logic [IDX_W-1:0]  mem_rd_addr, mem_wr_addr;
  logic [15:0]       mem_wr_data;
  logic [15:0]       mem_q;
  logic              rd_pend_r, rd_last_r, fwd_r;
  logic [IDX_W-1:0]  rd_addr_r;
  logic [15:0]       fwd_data_r;

  logic              out_valid_r, out_load, out_free;
  fce_out_t          out_word_r, reply_word;

  logic [15:0]       rd_data;
  logic              d_zero, d_end, d_bad, cur_end, cur_bad;
  logic [IDX_W-1:0]  lim;
  logic              cnt_reach, remain_last, scan_hit, scan_issue;

  // Handshake outputs
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Read data with a same-address write of the previous cycle forwarded
  assign rd_data     = fwd_r ? fwd_data_r : mem_q;
  assign d_zero      = (rd_data == 16'd0);
  assign d_end       = (rd_data == END_MARK);
  assign d_bad       = is_bad(rd_data);
  assign cur_end     = (cur_r == END_MARK);
  assign cur_bad     = is_bad(cur_r);
  assign cnt_reach   = ((cnt_r + 12'd1) == amount_r);
  assign remain_last = (remain_r == 12'd1);
  assign scan_hit    = rd_pend_r && d_zero;

  // Scan limit: usable entries, capped by the table depth
  always_comb begin
    if (32'(cfg_dbc_r) > 32'(TABLE_ENTRIES - 1)) begin
      lim = IDX_W'(TABLE_ENTRIES - 1);
    end else begin
      lim = IDX_W'(cfg_dbc_r);
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_addr_r == IDX_W'(TABLE_ENTRIES - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_word.command)
            CMD_ALLOC: state_nxt = S_ALLOC_START;
            CMD_FREE:  state_nxt = S_FREE_START;
            CMD_SEEK:  state_nxt = S_SEEK_START;
            CMD_LOAD:  state_nxt = S_LOAD_START;
          endcase
        end
      end
      S_ALLOC_START: begin
        if (amount_r == 12'd0 || lim == '0) state_nxt = S_REPLY;
        else state_nxt = S_ALLOC_CNT;
      end
      S_ALLOC_CNT: begin
        priority if (scan_hit && cnt_reach) state_nxt = S_ALLOC_LINK;
        else if (rd_pend_r && rd_last_r) state_nxt = S_REPLY;
        else state_nxt = S_ALLOC_CNT;
      end
      S_ALLOC_LINK: begin
        if (scan_hit && cnt_reach) state_nxt = S_ALLOC_END;
      end
      S_ALLOC_END: state_nxt = S_REPLY;
      S_FREE_START: begin
        if (cur_end || cur_bad) state_nxt = S_REPLY;
        else state_nxt = S_FREE_RUN;
      end
      S_FREE_RUN: begin
        if (d_zero || d_end || d_bad) state_nxt = S_REPLY;
      end
      S_SEEK_START: begin
        if (remain_r == 12'd0 || cur_end || cur_bad) state_nxt = S_REPLY;
        else state_nxt = S_SEEK_RUN;
      end
      S_SEEK_RUN: begin
        if (d_zero || remain_last || d_end || d_bad) state_nxt = S_REPLY;
      end
      S_LOAD_START: begin
        if (cur_bad) state_nxt = S_REPLY;
        else state_nxt = S_LOAD_RUN;
      end
      S_LOAD_RUN: state_nxt = S_REPLY;
      S_REPLY: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    cmd_nxt       = cmd_r;
    status_nxt    = status_r;
    cur_nxt       = cur_r;
    value_nxt     = value_r;
    result_nxt    = result_r;
    amount_nxt    = amount_r;
    remain_nxt    = remain_r;
    cnt_nxt       = cnt_r;
    freed_nxt     = freed_r;
    prev_nxt      = prev_r;
    scan_addr_nxt = scan_addr_r;
    scan_on_nxt   = scan_on_r;
    clr_addr_nxt  = clr_addr_r;
    occ_nxt       = occ_r;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = cur_r[IDX_W-1:0];
    mem_wr_en     = 1'b0;
    mem_wr_addr   = cur_r[IDX_W-1:0];
    mem_wr_data   = 16'd0;
    out_load      = 1'b0;
    scan_issue    = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        mem_wr_en    = 1'b1;
        mem_wr_addr  = clr_addr_r;
        mem_wr_data  = (clr_addr_r == '0) ? END_MARK : 16'd0;
        clr_addr_nxt = clr_addr_r + IDX_W'(1);
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt    = in_word.command;
          cur_nxt    = in_word.start_index;
          amount_nxt = in_word.amount;
          remain_nxt = in_word.amount;
          value_nxt  = in_word.entry_value;
          status_nxt = STAT_OK;
          result_nxt = 16'd0;
          freed_nxt  = 12'd0;
          cnt_nxt    = 12'd0;
        end
      end
      S_ALLOC_START: begin
        priority if (amount_r == 12'd0) begin
          result_nxt = END_MARK;
        end else if (lim == '0) begin
          status_nxt = STAT_NO_SPACE;
        end else begin
          scan_addr_nxt = IDX_W'(1);
          scan_on_nxt   = 1'b1;
        end
      end
      S_ALLOC_CNT: begin
        // count free entries until enough are seen or the scan runs out
        priority if (scan_hit && cnt_reach) begin
          cnt_nxt       = 12'd0;
          scan_addr_nxt = IDX_W'(1);
          scan_on_nxt   = 1'b1;
        end else if (rd_pend_r && rd_last_r) begin
          status_nxt  = STAT_NO_SPACE;
          scan_on_nxt = 1'b0;
        end else begin
          if (scan_hit) cnt_nxt = cnt_r + 12'd1;
          scan_issue = scan_on_r;
        end
      end
      S_ALLOC_LINK: begin
        // link each free entry found to the previous one
        if (scan_hit) begin
          if (cnt_r == 12'd0) begin
            result_nxt = 16'(rd_addr_r);
          end else begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = prev_r;
            mem_wr_data = 16'(rd_addr_r);
          end
          prev_nxt = rd_addr_r;
          cnt_nxt  = cnt_r + 12'd1;
        end
        if (scan_hit && cnt_reach) scan_on_nxt = 1'b0;
        else scan_issue = scan_on_r;
      end
      S_ALLOC_END: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = prev_r;
        mem_wr_data = END_MARK;
        occ_nxt     = occ_r + OCC_W'(amount_r);
      end
      S_FREE_START: begin
        priority if (cur_end) begin
          status_nxt = STAT_OK;
        end else if (cur_bad) begin
          status_nxt = STAT_BAD_INDEX;
        end else begin
          mem_rd_en = 1'b1;
        end
      end
      S_FREE_RUN: begin
        if (d_zero) begin
          status_nxt = STAT_CHAIN_END;
        end else begin
          // release this entry and move to the next link
          mem_wr_en = 1'b1;
          freed_nxt = freed_r + 12'd1;
          occ_nxt   = occ_r - OCC_W'(1);
          cur_nxt   = rd_data;
          priority if (d_end) begin
            status_nxt = STAT_OK;
          end else if (d_bad) begin
            status_nxt = STAT_BAD_INDEX;
          end else begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = rd_data[IDX_W-1:0];
          end
        end
      end
      S_SEEK_START: begin
        priority if (remain_r == 12'd0) begin
          status_nxt = STAT_OK;
        end else if (cur_end) begin
          status_nxt = STAT_CHAIN_END;
        end else if (cur_bad) begin
          status_nxt = STAT_BAD_INDEX;
        end else begin
          mem_rd_en = 1'b1;
        end
      end
      S_SEEK_RUN: begin
        if (d_zero) begin
          status_nxt = STAT_CHAIN_END;
        end else begin
          cur_nxt    = rd_data;
          remain_nxt = remain_r - 12'd1;
          priority if (remain_last) begin
            status_nxt = STAT_OK;
          end else if (d_end) begin
            status_nxt = STAT_CHAIN_END;
          end else if (d_bad) begin
            status_nxt = STAT_BAD_INDEX;
          end else begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = rd_data[IDX_W-1:0];
          end
        end
      end
      S_LOAD_START: begin
        if (cur_bad) status_nxt = STAT_BAD_INDEX;
        else mem_rd_en = 1'b1;
      end
      S_LOAD_RUN: begin
        // write the new value and track the occupancy change
        mem_wr_en   = 1'b1;
        mem_wr_data = value_r;
        if (!d_zero && value_r == 16'd0) occ_nxt = occ_r - OCC_W'(1);
        if (d_zero && value_r != 16'd0)  occ_nxt = occ_r + OCC_W'(1);
      end
      S_REPLY: begin
        out_load = out_free;
      end
      default: begin
        clr_addr_nxt = '0;
      end
    endcase

    // issue the next scan read
    if (scan_issue) begin
      mem_rd_en     = 1'b1;
      mem_rd_addr   = scan_addr_r;
      scan_addr_nxt = scan_addr_r + IDX_W'(1);
      scan_on_nxt   = (scan_addr_r != lim);
    end
  end

  // Assemble the result word
  always_comb begin
    reply_word.status      = status_r;
    reply_word.freed_count = freed_r;
    unique case (cmd_r)
      CMD_ALLOC: reply_word.result_index = result_r;
      CMD_SEEK:  reply_word.result_index = cur_r;
      CMD_FREE,
      CMD_LOAD:  reply_word.result_index = 16'd0;
    endcase
    if (32'(cfg_dbc_r) > 32'(occ_r)) begin
      reply_word.free_entries = 12'(32'(cfg_dbc_r) - 32'(occ_r));
    end else begin
      reply_word.free_entries = 12'd0;
    end
  end

  // Table RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_wr_en) fat_mem[mem_wr_addr] <= mem_wr_data;
  end

  always_ff @(posedge clk) begin
    if (mem_rd_en) mem_q <= fat_mem[mem_rd_addr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      occ_r       <= OCC_W'(1);
      scan_on_r   <= 1'b0;
      rd_pend_r   <= 1'b0;
      fwd_r       <= 1'b0;
      cfg_dbc_r   <= DBC_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      occ_r      <= occ_nxt;
      scan_on_r  <= scan_on_nxt;
      rd_pend_r  <= mem_rd_en;
      fwd_r      <= mem_rd_en && mem_wr_en && (mem_rd_addr == mem_wr_addr);
      if (cfg_valid) cfg_dbc_r <= cfg_data;
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    status_r    <= status_nxt;
    cur_r       <= cur_nxt;
    value_r     <= value_nxt;
    result_r    <= result_nxt;
    amount_r    <= amount_nxt;
    remain_r    <= remain_nxt;
    cnt_r       <= cnt_nxt;
    freed_r     <= freed_nxt;
    prev_r      <= prev_nxt;
    scan_addr_r <= scan_addr_nxt;
    rd_addr_r   <= mem_rd_addr;
    rd_last_r   <= (mem_rd_addr == lim);
    fwd_data_r  <= mem_wr_data;
    if (out_load) out_word_r <= reply_word;
  end

  // Entry zero is written only by the clearing pass
  a_entry_zero_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_wr_en && state_r != S_CLEAR) |-> (mem_wr_addr != '0))
    else $error("write to reserved entry zero");

  // Occupancy always counts entry zero and never exceeds the table
  a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r != '0) && (32'(occ_r) <= 32'(TABLE_ENTRIES)))
    else $error("occupied count out of range");

  // A link write during allocation lands below the entry being scanned
  a_link_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ALLOC_LINK && mem_wr_en) |-> (mem_wr_addr < rd_addr_r))
    else $error("allocation link written out of order");

  // A result word appears only after the reply state
  a_reply_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_REPLY))
    else $error("result word raised outside reply");

endmodule
